[rtl/frc_pkg.sv]
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and codes for the fraction reduce and compare block.
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam logic [1:0] ORDER_LESS    = 2'd0;
    localparam logic [1:0] ORDER_EQUAL   = 2'd1;
    localparam logic [1:0] ORDER_GREATER = 2'd2;

    typedef enum logic [2:0] {
        TOP_IDLE,
        TOP_START_A,
        TOP_WAIT_A,
        TOP_START_B,
        TOP_WAIT_B,
        TOP_MUL_LEFT,
        TOP_MUL_RIGHT,
        TOP_COMPARE
    } frc_top_state_t;

    typedef enum logic [2:0] {
        CORE_IDLE,
        CORE_GCD,
        CORE_DIV_NUM,
        CORE_DIV_DEN,
        CORE_DONE
    } frc_core_state_t;

    typedef struct packed {
        logic done;
    } frc_core_stat_t;

endpackage

[rtl/frc_in_if.sv]
// ----------------------------------------------------------------------------
// frc_in_if
// Operand channel: two signed fractions per transaction.
// ----------------------------------------------------------------------------
interface frc_in_if #(
    parameter int VALUE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] a_num;
    logic signed [VALUE_WIDTH-1:0] a_den;
    logic signed [VALUE_WIDTH-1:0] b_num;
    logic signed [VALUE_WIDTH-1:0] b_den;

    modport source (output valid, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, a_num, a_den, b_num, b_den, output ready);
endinterface

[rtl/frc_out_if.sv]
// ----------------------------------------------------------------------------
// frc_out_if
// Result channel: both reduced fractions and their order per transaction.
// ----------------------------------------------------------------------------
interface frc_out_if #(
    parameter int VALUE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] a_num_reduced;
    logic signed [VALUE_WIDTH-1:0] a_den_reduced;
    logic signed [VALUE_WIDTH-1:0] b_num_reduced;
    logic signed [VALUE_WIDTH-1:0] b_den_reduced;
    logic [1:0]                    order;

    modport source (output valid, a_num_reduced, a_den_reduced, b_num_reduced,
                    b_den_reduced, order, input ready);
    modport sink   (input valid, a_num_reduced, a_den_reduced, b_num_reduced,
                    b_den_reduced, order, output ready);
endinterface

[rtl/frc_reduce_core.sv]
// ----------------------------------------------------------------------------
// frc_reduce_core
// Reduces one signed fraction by the gcd of its magnitudes: binary gcd, then
// two restoring divisions (skipped when both magnitudes are zero), all through one shared subtractor.
// ----------------------------------------------------------------------------
module frc_reduce_core
    import frc_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [VALUE_WIDTH-1:0] num,
    input  logic signed [VALUE_WIDTH-1:0] den,
    output frc_core_stat_t                stat,
    output logic signed [VALUE_WIDTH-1:0] num_reduced,
    output logic signed [VALUE_WIDTH-1:0] den_reduced
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W);

    frc_core_state_t state_reg, state_next;

    logic          num_neg_reg, num_neg_next;
    logic          den_neg_reg, den_neg_next;
    logic [W-1:0]  mag_n_reg, mag_n_next;
    logic [W-1:0]  mag_d_reg, mag_d_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [CW-1:0] k_reg, k_next;
    logic [W-1:0]  g_reg, g_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  qn_reg, qn_next;
    logic [W-1:0]  qd_reg, qd_next;

    logic [W-1:0]  num_u;
    logic [W-1:0]  den_u;
    logic [W-1:0]  mag_num;
    logic [W-1:0]  mag_den;
    logic [W:0]    sub_a;
    logic [W:0]    sub_b;
    logic [W+1:0]  sub_diff;
    logic          sub_ge;
    logic          gcd_end;
    logic [W-1:0]  gcd_val;
    logic [W-1:0]  quo_step;
    logic          div_last;

    assign num_u   = num;
    assign den_u   = den;
    assign mag_num = num_u[W-1] ? ({W{1'b0}} - num_u) : num_u;
    assign mag_den = den_u[W-1] ? ({W{1'b0}} - den_u) : den_u;

    always_comb
    begin
        if (state_reg == CORE_GCD)
        begin
            sub_a = {1'b0, x_reg};
            sub_b = {1'b0, y_reg};
        end
        else
        begin
            sub_a = {rem_reg, quo_reg[W-1]};
            sub_b = {1'b0, g_reg};
        end
    end

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = !sub_diff[W+1];
    assign gcd_end  = (x_reg == '0) || (y_reg == '0);
    assign gcd_val  = (x_reg | y_reg) << k_reg;
    assign quo_step = {quo_reg[W-2:0], sub_ge};
    assign div_last = (cnt_reg == CW'(W - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CORE_IDLE:
            begin
                if (start)
                begin
                    state_next = CORE_GCD;
                end
            end
            CORE_GCD:
            begin
                if (gcd_end)
                begin
                    state_next = (gcd_val == '0) ? CORE_DONE : CORE_DIV_NUM;
                end
            end
            CORE_DIV_NUM:
            begin
                if (div_last)
                begin
                    state_next = CORE_DIV_DEN;
                end
            end
            CORE_DIV_DEN:
            begin
                if (div_last)
                begin
                    state_next = CORE_DONE;
                end
            end
            CORE_DONE:
            begin
                state_next = CORE_IDLE;
            end
            default:
            begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        num_neg_next = num_neg_reg;
        den_neg_next = den_neg_reg;
        mag_n_next   = mag_n_reg;
        mag_d_next   = mag_d_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        k_next       = k_reg;
        g_next       = g_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        qn_next      = qn_reg;
        qd_next      = qd_reg;
        case (state_reg)
            CORE_IDLE:
            begin
                if (start)
                begin
                    num_neg_next = num_u[W-1];
                    den_neg_next = den_u[W-1];
                    mag_n_next   = mag_num;
                    mag_d_next   = mag_den;
                    x_next       = mag_num;
                    y_next       = mag_den;
                    k_next       = '0;
                end
            end
            CORE_GCD:
            begin
                if (gcd_end)
                begin
                    g_next   = gcd_val;
                    qn_next  = mag_n_reg;
                    qd_next  = mag_d_reg;
                    quo_next = mag_n_reg;
                    rem_next = '0;
                    cnt_next = '0;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (sub_ge)
                begin
                    x_next = sub_diff[W-1:0];
                end
                else
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
            end
            CORE_DIV_NUM, CORE_DIV_DEN:
            begin
                rem_next = sub_ge ? sub_diff[W-1:0] : sub_a[W-1:0];
                quo_next = quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                begin
                    if (state_reg == CORE_DIV_NUM)
                    begin
                        qn_next  = quo_step;
                        quo_next = mag_d_reg;
                        rem_next = '0;
                        cnt_next = '0;
                    end
                    else
                    begin
                        qd_next = quo_step;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_neg_reg <= num_neg_next;
        den_neg_reg <= den_neg_next;
        mag_n_reg   <= mag_n_next;
        mag_d_reg   <= mag_d_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        k_reg       <= k_next;
        g_reg       <= g_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        qn_reg      <= qn_next;
        qd_reg      <= qd_next;
    end

    assign stat.done   = (state_reg == CORE_DONE);
    assign num_reduced = num_neg_reg ? ({W{1'b0}} - qn_reg) : qn_reg;
    assign den_reduced = den_neg_reg ? ({W{1'b0}} - qd_reg) : qd_reg;

endmodule

[rtl/fraction_reduce_and_compare_top.sv]
// ----------------------------------------------------------------------------
// fraction_reduce_and_compare_top
// Reduces two signed fractions by their gcds and orders them by cross product.
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  operands  sink       valid / ready  a_num, a_den, b_num, b_den
//  result    source     valid / ready  a/b num/den reduced, order
//
//  One transaction at a time; ready is high only in the idle state.
//  Each fraction runs through the reduce core: binary gcd plus two W-bit
//  divisions; then two multiply steps form the cross products, and a compare.
//  The result register frees the input side while a result waits.
//  rst_n clears the sequencers and the result valid flag asynchronously.
// ----------------------------------------------------------------------------
module fraction_reduce_and_compare_top
    import frc_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)(
    input  logic      clk,
    input  logic      rst_n,
    frc_in_if.sink    operands,
    frc_out_if.source result
);

    localparam int W = VALUE_WIDTH;

    frc_top_state_t state_reg, state_next;

    logic signed [W-1:0]   an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [2*W-1:0] left_reg, right_reg;
    logic signed [W-1:0]   out_an_reg, out_ad_reg, out_bn_reg, out_bd_reg;
    logic [1:0]            out_order_reg;
    logic                  out_valid_reg, out_valid_next;

    logic                  in_ready;
    logic                  core_start;
    logic                  load_a;
    logic                  load_b;
    logic                  out_load;
    logic                  out_free;
    logic signed [W-1:0]   core_num;
    logic signed [W-1:0]   core_den;
    frc_core_stat_t        core_stat;
    logic signed [W-1:0]   core_num_red;
    logic signed [W-1:0]   core_den_red;
    logic signed [W-1:0]   mul_x;
    logic signed [W-1:0]   mul_y;
    logic signed [2*W-1:0] mul_prod;
    logic [1:0]            order_calc;

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TOP_IDLE:
            begin
                if (operands.valid)
                begin
                    state_next = TOP_START_A;
                end
            end
            TOP_START_A:   state_next = TOP_WAIT_A;
            TOP_WAIT_A:
            begin
                if (core_stat.done)
                begin
                    state_next = TOP_START_B;
                end
            end
            TOP_START_B:   state_next = TOP_WAIT_B;
            TOP_WAIT_B:
            begin
                if (core_stat.done)
                begin
                    state_next = TOP_MUL_LEFT;
                end
            end
            TOP_MUL_LEFT:  state_next = TOP_MUL_RIGHT;
            TOP_MUL_RIGHT: state_next = TOP_COMPARE;
            TOP_COMPARE:
            begin
                if (out_free)
                begin
                    state_next = TOP_IDLE;
                end
            end
            default:       state_next = TOP_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        core_start = 1'b0;
        load_a     = 1'b0;
        load_b     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            TOP_IDLE:    in_ready   = 1'b1;
            TOP_START_A,
            TOP_START_B: core_start = 1'b1;
            TOP_WAIT_A:  load_a     = core_stat.done;
            TOP_WAIT_B:  load_b     = core_stat.done;
            TOP_COMPARE: out_load   = out_free;
            default:
            begin
            end
        endcase
    end

    assign core_num = (state_reg == TOP_START_A) ? an_reg : bn_reg;
    assign core_den = (state_reg == TOP_START_A) ? ad_reg : bd_reg;

    frc_reduce_core #(
        .VALUE_WIDTH (W)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (core_start),
        .num         (core_num),
        .den         (core_den),
        .stat        (core_stat),
        .num_reduced (core_num_red),
        .den_reduced (core_den_red)
    );

    assign mul_x    = (state_reg == TOP_MUL_LEFT) ? an_reg : bn_reg;
    assign mul_y    = (state_reg == TOP_MUL_LEFT) ? bd_reg : ad_reg;
    assign mul_prod = (2*W)'(mul_x) * (2*W)'(mul_y);

    always_comb
    begin
        if (left_reg < right_reg)
        begin
            order_calc = ORDER_LESS;
        end
        else if (left_reg == right_reg)
        begin
            order_calc = ORDER_EQUAL;
        end
        else
        begin
            order_calc = ORDER_GREATER;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TOP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && operands.valid)
        begin
            an_reg <= operands.a_num;
            ad_reg <= operands.a_den;
            bn_reg <= operands.b_num;
            bd_reg <= operands.b_den;
        end
        if (load_a)
        begin
            an_reg <= core_num_red;
            ad_reg <= core_den_red;
        end
        if (load_b)
        begin
            bn_reg <= core_num_red;
            bd_reg <= core_den_red;
        end
        if (state_reg == TOP_MUL_LEFT)
        begin
            left_reg <= mul_prod;
        end
        if (state_reg == TOP_MUL_RIGHT)
        begin
            right_reg <= mul_prod;
        end
        if (out_load)
        begin
            out_an_reg    <= an_reg;
            out_ad_reg    <= ad_reg;
            out_bn_reg    <= bn_reg;
            out_bd_reg    <= bd_reg;
            out_order_reg <= order_calc;
        end
    end

    assign operands.ready       = in_ready;
    assign result.valid         = out_valid_reg;
    assign result.a_num_reduced = out_an_reg;
    assign result.a_den_reduced = out_ad_reg;
    assign result.b_num_reduced = out_bn_reg;
    assign result.b_den_reduced = out_bd_reg;
    assign result.order         = out_order_reg;

endmodule

[rtl/frc_checker.sv]
// ----------------------------------------------------------------------------
// frc_checker
// Port-level checks for the fraction reduce and compare block.
// ----------------------------------------------------------------------------
module frc_checker
    import frc_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [VALUE_WIDTH-1:0] a_num_reduced,
    input logic signed [VALUE_WIDTH-1:0] a_den_reduced,
    input logic signed [VALUE_WIDTH-1:0] b_num_reduced,
    input logic signed [VALUE_WIDTH-1:0] b_den_reduced,
    input logic [1:0]                    order
);

    localparam logic signed [VALUE_WIDTH-1:0] ONE     = VALUE_WIDTH'(1);
    localparam logic signed [VALUE_WIDTH-1:0] NEG_ONE = {VALUE_WIDTH{1'b1}};

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("operand channel ready right after a transaction");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (order == ORDER_LESS || order == ORDER_EQUAL
                       || order == ORDER_GREATER))
        else $error("order code out of range");

    a_zero_den_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && a_den_reduced == '0 |->
            (a_num_reduced == '0 || a_num_reduced == ONE || a_num_reduced == NEG_ONE))
        else $error("zero denominator with unreduced numerator");

    a_same_equal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && a_num_reduced == b_num_reduced
            && a_den_reduced == b_den_reduced |-> order == ORDER_EQUAL)
        else $error("identical fractions not ordered equal");

endmodule

bind fraction_reduce_and_compare_top frc_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_frc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (operands.valid),
    .in_ready      (operands.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .a_num_reduced (result.a_num_reduced),
    .a_den_reduced (result.a_den_reduced),
    .b_num_reduced (result.b_num_reduced),
    .b_den_reduced (result.b_den_reduced),
    .order         (result.order)
);
